@@ rtl/core/elevation_min_max_gray_stretch_core_assert.svh @@
// assertion macros for the elevation gray stretch core
// used by the top level only, no other dependencies
`ifndef ELEVATION_MIN_MAX_GRAY_STRETCH_CORE_ASSERT_SVH
`define ELEVATION_MIN_MAX_GRAY_STRETCH_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define EMGS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define EMGS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/emgs_pkg.sv @@
// shared types and constants of the elevation gray stretch core
// no dependencies
package emgs_pkg;

  localparam int SAMPLE_BITS      = 24;
  localparam int INDEX_BITS       = 16;
  localparam int GRAY_BITS        = 8;
  localparam int GRAY_MAX         = 255;
  localparam int MAX_PIXELS_DEF   = 65536;
  localparam int CMD_QUEUE_DEPTH  = 2;
  localparam int NODATA_RESET     = -99999;

  typedef logic [1:0] opcode_t;

  localparam opcode_t OP_START = 2'd0;
  localparam opcode_t OP_LOAD  = 2'd1;
  localparam opcode_t OP_READ  = 2'd2;
  localparam opcode_t OP_NONE  = 2'd3;

  typedef struct packed {
    opcode_t                      op;
    logic [INDEX_BITS-1:0]        index;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                         in_range;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

@@ rtl/core/emgs_if.sv @@
// handshake channels of the elevation gray stretch core
// depends on emgs_pkg
interface emgs_in_if;
  import emgs_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [1:0]                    opcode;
  logic [INDEX_BITS-1:0]         index;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output opcode, output index, output sample, input ready);
  modport sink   (input valid, input opcode, input index, input sample, output ready);
endinterface

interface emgs_out_if;
  import emgs_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [GRAY_BITS-1:0] gray;
  logic                 is_data;

  modport source (output valid, output gray, output is_data, input ready);
  modport sink   (input valid, input gray, input is_data, output ready);
endinterface

interface emgs_cfg_if;
  import emgs_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/emgs_ram.sv @@
// generic simple dual port ram with registered read
// no dependencies
module emgs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

@@ rtl/core/emgs_cmd_fifo.sv @@
// short command queue between front and back
// depends on emgs_pkg
module emgs_cmd_fifo #(
  parameter int DEPTH = emgs_pkg::CMD_QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  emgs_pkg::cmd_t      push_cmd_i,
  input  logic                pop_i,
  output emgs_pkg::cmd_t      head_o,
  output emgs_pkg::fifo_stat_t stat_o
);
  import emgs_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  cmd_t            entry_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign head_o       = entry_q[rd_ptr_q];
  assign stat_o.full  = (count_q == CntW'(DEPTH));
  assign stat_o.empty = (count_q == '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

@@ rtl/core/emgs_front.sv @@
// front end: accepts input words, checks range, drops words with no effect
// depends on emgs_pkg and emgs_if
module emgs_front #(
  parameter int MAX_PIXELS = emgs_pkg::MAX_PIXELS_DEF
) (
  emgs_in_if.sink              in_i,
  input  emgs_pkg::fifo_stat_t stat_i,
  output logic                 push_o,
  output emgs_pkg::cmd_t       cmd_o
);
  import emgs_pkg::*;

  logic in_range;
  logic keep;

  assign in_range   = (32'(in_i.index) < 32'(MAX_PIXELS));
  assign in_i.ready = !stat_i.full;

  // unused opcode and out of range loads change nothing
  always_comb begin
    case (in_i.opcode)
      OP_START: keep = 1'b1;
      OP_LOAD:  keep = in_range;
      OP_READ:  keep = 1'b1;
      default:  keep = 1'b0;
    endcase
  end

  assign push_o          = in_i.valid && in_i.ready && keep;
  assign cmd_o.op        = in_i.opcode;
  assign cmd_o.index     = in_i.index;
  assign cmd_o.sample    = in_i.sample;
  assign cmd_o.in_range  = in_range;

endmodule

@@ rtl/core/emgs_back.sv @@
// back end: store writes, extreme tracking, read and 8-step restoring divide
// depends on emgs_pkg, emgs_if and emgs_ram
module emgs_back #(
  parameter int MAX_PIXELS = emgs_pkg::MAX_PIXELS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  emgs_pkg::cmd_t                       head_i,
  input  emgs_pkg::fifo_stat_t                 stat_i,
  input  logic signed [emgs_pkg::SAMPLE_BITS-1:0] nodata_i,
  output logic                                 pop_o,
  emgs_out_if.source                           out_o
);
  import emgs_pkg::*;

  localparam int S     = SAMPLE_BITS;
  localparam int AddrW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int NumW  = S + 1 + GRAY_BITS;
  localparam int BitW  = $clog2(GRAY_BITS);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_DIV, S_DONE} state_e;

  state_e                 state_q;
  logic signed [S-1:0]    lo_q, hi_q;
  logic                   seen_q;
  logic                   rd_range_q;
  logic [NumW-1:0]        num_q;
  logic [S:0]             den_q;
  logic [GRAY_BITS-1:0]   quo_q;
  logic [BitW-1:0]        bit_q;
  logic [GRAY_BITS-1:0]   res_gray_q;
  logic                   res_data_q;
  logic                   out_valid_q;
  logic [GRAY_BITS-1:0]   gray_q;
  logic                   is_data_q;

  logic                   ram_we, ram_re;
  logic [31:0]            idx_ext;
  logic [S-1:0]           ram_rdata;
  logic signed [S-1:0]    h;
  logic signed [S-1:0]    s;
  logic signed [S:0]      off_s, span_s;
  logic [NumW-1:0]        num_init;
  logic [NumW-1:0]        trial;
  logic                   ge;
  logic [GRAY_BITS-1:0]   quo_next;
  logic                   out_free;

  assign idx_ext  = 32'(head_i.index);
  assign h        = $signed(ram_rdata);
  assign s        = $signed(head_i.sample);
  assign off_s    = {h[S-1], h} - {lo_q[S-1], lo_q};
  assign span_s   = {hi_q[S-1], hi_q} - {lo_q[S-1], lo_q};
  assign num_init = NumW'($unsigned(off_s)) * NumW'(GRAY_MAX);
  assign trial    = NumW'(den_q) << bit_q;
  assign ge       = (num_q >= trial);
  assign quo_next = quo_q | (ge ? (GRAY_BITS'(1) << bit_q) : '0);
  assign out_free = !out_valid_q || out_o.ready;

  assign out_o.valid   = out_valid_q;
  assign out_o.gray    = gray_q;
  assign out_o.is_data = is_data_q;

  always_comb begin
    pop_o  = 1'b0;
    ram_we = 1'b0;
    ram_re = 1'b0;
    if (state_q == S_IDLE && !stat_i.empty) begin
      pop_o = 1'b1;
      if (head_i.op == OP_LOAD) begin
        ram_we = 1'b1;
      end
      if (head_i.op == OP_READ && head_i.in_range) begin
        ram_re = 1'b1;
      end
    end
  end

  emgs_ram #(
    .WIDTH (S),
    .DEPTH (MAX_PIXELS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_ext[AddrW-1:0]),
    .wdata_i (head_i.sample),
    .re_i    (ram_re),
    .raddr_i (idx_ext[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      lo_q        <= '0;
      hi_q        <= '0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
      rd_range_q  <= 1'b0;
      num_q       <= '0;
      den_q       <= '0;
      quo_q       <= '0;
      bit_q       <= '0;
      res_gray_q  <= '0;
      res_data_q  <= 1'b0;
      gray_q      <= '0;
      is_data_q   <= 1'b0;
    end else begin
      if (out_o.valid && out_o.ready && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (!stat_i.empty) begin
            case (head_i.op)
              OP_START: begin
                lo_q   <= '0;
                hi_q   <= '0;
                seen_q <= 1'b0;
              end
              OP_LOAD: begin
                if (s != nodata_i) begin
                  if (!seen_q) begin
                    lo_q   <= s;
                    hi_q   <= s;
                    seen_q <= 1'b1;
                  end else if (s > hi_q) begin
                    hi_q <= s;
                  end else if (s < lo_q) begin
                    lo_q <= s;
                  end
                end
              end
              OP_READ: begin
                rd_range_q <= head_i.in_range;
                state_q    <= S_READ;
              end
              default: ;
            endcase
          end
        end
        S_READ: begin
          if (!rd_range_q || h == nodata_i) begin
            res_gray_q <= '0;
            res_data_q <= 1'b0;
            state_q    <= S_DONE;
          end else if (hi_q <= lo_q || h <= lo_q) begin
            res_gray_q <= '0;
            res_data_q <= 1'b1;
            state_q    <= S_DONE;
          end else if (h >= hi_q) begin
            res_gray_q <= GRAY_BITS'(GRAY_MAX);
            res_data_q <= 1'b1;
            state_q    <= S_DONE;
          end else begin
            num_q   <= num_init;
            den_q   <= $unsigned(span_s);
            quo_q   <= '0;
            bit_q   <= BitW'(GRAY_BITS - 1);
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          num_q <= ge ? num_q - trial : num_q;
          quo_q <= quo_next;
          if (bit_q == '0) begin
            res_gray_q <= quo_next;
            res_data_q <= 1'b1;
            state_q    <= S_DONE;
          end else begin
            bit_q <= bit_q - 1'b1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            gray_q      <= res_gray_q;
            is_data_q   <= res_data_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/elevation_min_max_gray_stretch_core.sv @@
// top level of the elevation min/max gray stretch core
// depends on emgs_pkg, emgs_if, emgs_front, emgs_cmd_fifo, emgs_back, emgs_ram
//
// channels: in_i carries opcode, index and sample words; out_o returns one
// gray/is_data word per read; cfg_i writes the no-data marker (always ready)
// opcodes: start grid clears the extremes, load stores a sample and updates
// the extremes, read returns the stretched gray level of a stored sample
// the front checks range and drops unused opcodes and out of range loads;
// a two-entry command queue feeds the back end
// handling: start and load are handled by the back end once at the queue head; a
// read passes from S_READ to S_DONE when saturated or no-data, else through the
// 8-step restoring divider first; the back end pops no command until it is done
// a stalled receiver holds the result register; the back end then waits,
// and the input stalls once the queue is full
// reset clears the extremes, the queue and the output valid; the no-data
// marker returns to -99999; the sample store is not cleared
`include "elevation_min_max_gray_stretch_core_assert.svh"

module elevation_min_max_gray_stretch_core #(
  parameter int MAX_PIXELS = emgs_pkg::MAX_PIXELS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  emgs_in_if.sink     in_i,
  emgs_out_if.source  out_o,
  emgs_cfg_if.sink    cfg_i
);
  import emgs_pkg::*;

  logic signed [SAMPLE_BITS-1:0] nodata_q;
  logic                          push;
  logic                          pop;
  cmd_t                          push_cmd;
  cmd_t                          head;
  fifo_stat_t                    stat;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nodata_q <= SAMPLE_BITS'(NODATA_RESET);
    end else if (cfg_i.valid && cfg_i.ready) begin
      nodata_q <= cfg_i.data;
    end
  end

  emgs_front #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_front (
    .in_i   (in_i),
    .stat_i (stat),
    .push_o (push),
    .cmd_o  (push_cmd)
  );

  emgs_cmd_fifo #(
    .DEPTH (CMD_QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head),
    .stat_o     (stat)
  );

  emgs_back #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .stat_i   (stat),
    .nodata_i (nodata_q),
    .pop_o    (pop),
    .out_o    (out_o)
  );

  `EMGS_ASSERT_NOW(a_no_push_full, clk_i, rst_ni, push, !stat.full, "push into full queue")
  `EMGS_ASSERT_NOW(a_no_pop_empty, clk_i, rst_ni, pop, !stat.empty, "pop from empty queue")
  `EMGS_ASSERT_NOW(a_unused_dropped, clk_i, rst_ni, in_i.valid && in_i.ready && in_i.opcode == OP_NONE, !push, "unused opcode queued")
  `EMGS_ASSERT_NOW(a_nodata_black, clk_i, rst_ni, out_o.valid && !out_o.is_data, out_o.gray == '0, "no-data result not black")

endmodule

@@ dv/elevation_min_max_gray_stretch_core_tb.sv @@
// testbench of elevation_min_max_gray_stretch_core: directed and random grids of
// load, read, start and unused words checked against a min/max gray stretch scoreboard
// depends on emgs_pkg, emgs_if and the core
module elevation_min_max_gray_stretch_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import emgs_pkg::*;

  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_WORDS = 1450;
  localparam int PHASES       = 8;

  typedef struct packed {
    logic [GRAY_BITS-1:0] gray;
    logic                 is_data;
  } gray_word_t;

  class stretch_scoreboard;
    logic signed [SAMPLE_BITS-1:0] heights [MAX_PIXELS_DEF];
    bit                            written [MAX_PIXELS_DEF];
    int unsigned                   loaded [$];
    logic signed [SAMPLE_BITS-1:0] lowest;
    logic signed [SAMPLE_BITS-1:0] highest;
    logic signed [SAMPLE_BITS-1:0] nodata;
    bit                            seen_valid;
    gray_word_t                    gray_expected [$];
    int                            errors;

    function new();
      lowest     = '0;
      highest    = '0;
      seen_valid = 1'b0;
      nodata     = SAMPLE_BITS'(NODATA_RESET);
      errors     = 0;
    endfunction

    function logic [GRAY_BITS-1:0] stretched(logic signed [SAMPLE_BITS-1:0] h);
      longint span;
      longint off;
      if (highest <= lowest || h <= lowest) return '0;
      if (h >= highest) return GRAY_BITS'(GRAY_MAX);
      span = longint'(highest) - longint'(lowest);
      off  = longint'(h) - longint'(lowest);
      return GRAY_BITS'((off * GRAY_MAX) / span);
    endfunction

    function void note_word(opcode_t op, logic [INDEX_BITS-1:0] idx,
                            logic signed [SAMPLE_BITS-1:0] s);
      gray_word_t w;
      case (op)
        OP_START: begin
          lowest     = '0;
          highest    = '0;
          seen_valid = 1'b0;
        end
        OP_LOAD: begin
          heights[idx] = s;
          if (!written[idx]) begin
            written[idx] = 1'b1;
            loaded.insert(loaded.size(), idx);
          end
          if (s != nodata) begin
            if (!seen_valid) begin
              lowest     = s;
              highest    = s;
              seen_valid = 1'b1;
            end else if (s > highest) begin
              highest = s;
            end else if (s < lowest) begin
              lowest = s;
            end
          end
        end
        OP_READ: begin
          if (heights[idx] == nodata) begin
            w.gray    = '0;
            w.is_data = 1'b0;
          end else begin
            w.gray    = stretched(heights[idx]);
            w.is_data = 1'b1;
          end
          gray_expected.insert(gray_expected.size(), w);
        end
        default: ;
      endcase
    endfunction

    function void check_word(logic [GRAY_BITS-1:0] g, logic d);
      gray_word_t w;
      if (gray_expected.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual gray %0d is_data %0b",
                 $time, g, d);
        errors++;
        return;
      end
      w = gray_expected.pop_front();
      if (g !== w.gray) begin
        $display("%0t: gray mismatch, expected %0d, actual %0d", $time, w.gray, g);
        errors++;
      end
      if (d !== w.is_data) begin
        $display("%0t: is_data mismatch, expected %0b, actual %0b", $time, w.is_data, d);
        errors++;
      end
    endfunction

    function int unsigned any_loaded();
      return loaded[$urandom_range(0, loaded.size() - 1)];
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  bit   quiet;
  bit   calm;
  int   sent_items;

  stretch_scoreboard sb = new();

  emgs_in_if  in_if ();
  emgs_out_if out_if ();
  emgs_cfg_if cfg_if ();

  elevation_min_max_gray_stretch_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) sb.check_word(out_if.gray, out_if.is_data);
  end

  initial begin : receiver
    int hold;
    hold = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        out_if.ready = 1'b0;
        hold--;
      end else if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
        out_if.ready = 1'b0;
        hold = $urandom_range(0, 3);
      end else begin
        out_if.ready = 1'b1;
      end
    end
  end

  task automatic send_word(opcode_t op, logic [INDEX_BITS-1:0] idx,
                           logic signed [SAMPLE_BITS-1:0] s);
    int gap;
    gap = (!quiet && !calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid  = 1'b1;
    in_if.opcode = op;
    in_if.index  = idx;
    in_if.sample = s;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_word(op, idx, s);
    if (op != OP_NONE) sent_items++;
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (sb.gray_expected.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_nodata(logic signed [SAMPLE_BITS-1:0] v);
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    cfg_if.valid = 1'b1;
    cfg_if.data  = v;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.nodata = v;
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  // one grid: start, loads clustered around a window, then mostly reads of them
  task automatic run_grid(int n_loads, int n_reads);
    logic [INDEX_BITS-1:0]         here [$];
    logic [INDEX_BITS-1:0]         base;
    logic [INDEX_BITS-1:0]         idx;
    logic signed [SAMPLE_BITS-1:0] center;
    logic signed [SAMPLE_BITS-1:0] s;
    int                            span_bits;
    int                            k;
    base      = INDEX_BITS'($urandom);
    center    = SAMPLE_BITS'($urandom);
    span_bits = $urandom_range(0, 23);
    calm      = ($urandom_range(0, 3) == 0);
    send_word(OP_START, INDEX_BITS'($urandom), SAMPLE_BITS'($urandom));
    for (k = 0; k < n_loads + n_reads; k++) begin
      if (k < n_loads || $urandom_range(0, 19) == 0) begin
        if ($urandom_range(0, 9) < 7) idx = base + INDEX_BITS'($urandom_range(0, 63));
        else idx = INDEX_BITS'($urandom);
        case ($urandom_range(0, 19))
          0, 1: s = sb.nodata;
          2: s = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
          3: s = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
          4, 5: s = SAMPLE_BITS'($urandom);
          default: s = center + SAMPLE_BITS'($urandom & ((32'd1 << span_bits) - 1));
        endcase
        send_word(OP_LOAD, idx, s);
        here.insert(here.size(), idx);
        if (k == n_loads - 1 && $urandom_range(0, 9) == 0) settle();
      end else begin
        case ($urandom_range(0, 24))
          0: send_word(OP_START, INDEX_BITS'($urandom), SAMPLE_BITS'($urandom));
          1: send_word(OP_NONE, INDEX_BITS'($urandom), SAMPLE_BITS'($urandom));
          2, 3, 4:
            send_word(OP_READ, INDEX_BITS'(sb.any_loaded()), SAMPLE_BITS'($urandom));
          default:
            send_word(OP_READ, here[$urandom_range(0, here.size() - 1)],
                      SAMPLE_BITS'($urandom));
        endcase
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    int p;
    int target;
    logic signed [SAMPLE_BITS-1:0] marker;
    rst_ni       = 1'b0;
    quiet        = 1'b0;
    calm         = 1'b0;
    sent_items   = 0;
    in_if.valid  = 1'b0;
    in_if.opcode = OP_START;
    in_if.index  = '0;
    in_if.sample = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: first valid load, extremes, no-data, flat grid, saturation
    send_word(OP_START, '0, '0);
    send_word(OP_LOAD, 16'd0, {1'b1, {(SAMPLE_BITS-1){1'b0}}});
    send_word(OP_READ, 16'd0, '0);
    send_word(OP_LOAD, 16'hFFFF, {1'b0, {(SAMPLE_BITS-1){1'b1}}});
    send_word(OP_LOAD, 16'd1, '0);
    send_word(OP_LOAD, 16'd2, SAMPLE_BITS'(NODATA_RESET));
    send_word(OP_READ, 16'd0, '0);
    send_word(OP_READ, 16'hFFFF, '0);
    send_word(OP_READ, 16'd1, '0);
    send_word(OP_READ, 16'd2, '0);
    send_word(OP_NONE, 16'd3, 24'sd5);
    send_word(OP_START, '0, '0);
    send_word(OP_READ, 16'd1, '0);
    send_word(OP_LOAD, 16'd3, 24'sd100);
    send_word(OP_LOAD, 16'd4, 24'sd200);
    send_word(OP_READ, 16'd1, '0);
    send_word(OP_READ, 16'hFFFF, '0);
    send_word(OP_READ, 16'd3, '0);
    send_word(OP_READ, 16'd4, '0);
    send_word(OP_LOAD, 16'd5, 24'sd150);
    send_word(OP_READ, 16'd5, '0);
    write_nodata('0);
    send_word(OP_READ, 16'd1, '0);
    send_word(OP_READ, 16'd2, '0);
    send_word(OP_READ, 16'd5, '0);

    target = sent_items;
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: marker = SAMPLE_BITS'(NODATA_RESET);
        1: marker = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        2: marker = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        3: marker = '0;
        default: marker = SAMPLE_BITS'($urandom);
      endcase
      write_nodata(marker);
      target += RANDOM_WORDS / PHASES;
      while (sent_items < target) begin
        if (sent_items > target - RANDOM_WORDS / PHASES + 20 &&
            p == PHASES - 1) quiet = 1'b1;
        if ($urandom_range(0, 4) == 0) run_grid($urandom_range(1, 4), $urandom_range(1, 6));
        else run_grid($urandom_range(4, 20), $urandom_range(4, 20));
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.gray_expected.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/emgs_pkg.sv
rtl/core/emgs_if.sv
rtl/core/emgs_ram.sv
rtl/core/emgs_cmd_fifo.sv
rtl/core/emgs_front.sv
rtl/core/emgs_back.sv
rtl/core/elevation_min_max_gray_stretch_core.sv
dv/elevation_min_max_gray_stretch_core_tb.sv
